// ----- hw/rtl/efcu_pkg.sv -----
package efcu_pkg;

    typedef struct packed {
        logic [2:0]         move_direction;
        logic [15:0]        delta_time;
        logic signed [15:0] mouse_dx;
        logic signed [15:0] mouse_dy;
        logic               constrain_pitch;
        logic signed [15:0] scroll_offset;
    } efcu_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic [13:0]        zoom_level;
    } efcu_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VEL,
        ST_MOVE,
        ST_YAW_MUL,
        ST_PITCH_MUL,
        ST_WRAP,
        ST_CINIT,
        ST_CORDIC,
        ST_FRONT,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_CROSS,
        ST_DONE
    } state_t;

    // which vector a normalization writes
    typedef enum logic [1:0] {
        VSEL_FRONT,
        VSEL_RIGHT,
        VSEL_UP
    } vsel_t;

    localparam logic [2:0] DIR_NONE     = 3'd0;
    localparam logic [2:0] DIR_FORWARD  = 3'd1;
    localparam logic [2:0] DIR_BACKWARD = 3'd2;
    localparam logic [2:0] DIR_LEFT     = 3'd3;
    localparam logic [2:0] DIR_RIGHT    = 3'd4;
    localparam logic [2:0] DIR_UP       = 3'd5;
    localparam logic [2:0] DIR_DOWN     = 3'd6;

    localparam logic [2:0] REG_SPEED = 3'd0;
    localparam logic [2:0] REG_SENS  = 3'd1;
    localparam logic [2:0] REG_WUP_X = 3'd2;
    localparam logic [2:0] REG_WUP_Y = 3'd3;
    localparam logic [2:0] REG_WUP_Z = 3'd4;

    localparam logic [15:0] SPEED_RST = 16'd640;
    localparam logic [15:0] SENS_RST  = 16'd6554;

    localparam logic signed [15:0] ONE_Q14   = 16'sd16384;
    localparam logic signed [15:0] YAW_RST   = -16'sd11520;
    localparam logic [13:0]        ZOOM_MIN  = 14'd256;
    localparam logic [13:0]        ZOOM_MAX  = 14'd11520;
    localparam int                 DEG90     = 11520;
    localparam int                 DEG180    = 23040;
    localparam int                 DEG360    = 46080;
    localparam int                 PITCH_LIM = 11392;
    localparam int                 CORDIC_GAIN = 652032874;

    // arctangent of 2^-i in 2^-16 degree
    function automatic logic signed [25:0] atan_entry(input logic [4:0] i);
        logic signed [25:0] v;
        case (i)
            5'd0:  v = 26'sd2949120;
            5'd1:  v = 26'sd1740967;
            5'd2:  v = 26'sd919879;
            5'd3:  v = 26'sd466945;
            5'd4:  v = 26'sd234379;
            5'd5:  v = 26'sd117304;
            5'd6:  v = 26'sd58666;
            5'd7:  v = 26'sd29335;
            5'd8:  v = 26'sd14668;
            5'd9:  v = 26'sd7334;
            5'd10: v = 26'sd3667;
            5'd11: v = 26'sd1833;
            5'd12: v = 26'sd917;
            5'd13: v = 26'sd458;
            5'd14: v = 26'sd229;
            5'd15: v = 26'sd115;
            5'd16: v = 26'sd57;
            5'd17: v = 26'sd29;
            5'd18: v = 26'sd14;
            5'd19: v = 26'sd7;
            5'd20: v = 26'sd4;
            5'd21: v = 26'sd2;
            5'd22: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/euler_fly_camera_update.sv -----
// Fly-camera update with Euler angles, fixed point.
// Input channel s_valid/s_ready/s_data carries one event frame: a move along
// front, right or world up, mouse offsets for yaw and pitch, and a scroll
// offset for zoom. Output channel m_valid/m_ready/m_data carries one result
// per frame: position, front and up vectors, yaw, pitch and zoom.
// Speed, sensitivity and world up sit on the APB port (byte addresses 0..16).
// The user must write them only while the block is idle; the block
// does not enforce this itself. pready is tied high. A frame without a move
// skips the move steps, and a zero vector skips its divides. All of it runs
// through one registered 33x33 multiplier, one CORDIC rotation step, one
// square-root step and one divide step a cycle under the sequencer; the
// three square roots and nine quotient divides take most of a frame's time.
// s_ready is high only while idle.
// A finished result sits in the output register until taken; the next frame
// may be accepted and worked meanwhile, and holds in its last step until the
// output register is free.
// Reset (aresetn low, synchronous) restores the default registers, position
// zero, yaw -90 degrees, pitch zero, zoom 45 and the default basis vectors.
module euler_fly_camera_update #(
    parameter int CORDIC_STEPS   = 16,
    parameter int POSITION_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [4:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  efcu_pkg::efcu_in_t      s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output efcu_pkg::efcu_out_t     m_data
);

    localparam int PW = POSITION_WIDTH;
    localparam int SW = ((PW > 27) ? PW : 27) + 2;
    localparam logic signed [SW-1:0] POS_MAX = SW'((64'sd1 <<< (PW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] POS_MIN = SW'(-(64'sd1 <<< (PW - 1)));
    localparam logic [4:0] CS_LAST = 5'(CORDIC_STEPS - 1);

    // configuration
    logic [15:0]        speed_reg;
    logic [15:0]        sens_reg;
    logic signed [15:0] wu_reg [3];

    // control
    efcu_pkg::state_t state_reg, state_next;
    efcu_pkg::vsel_t  vsel_reg, vsel_next;
    logic             ph_reg, ph_next;
    logic [1:0]       idx_reg, idx_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             asel_reg, asel_next;
    logic             m_valid_reg;
    logic             out_load;

    // camera state
    logic signed [PW-1:0] pos_reg [3];
    logic signed [15:0]   yaw_reg;
    logic signed [15:0]   pitch_reg;
    logic [13:0]          zoom_reg;
    logic signed [15:0]   front_reg [3];
    logic signed [15:0]   right_reg [3];
    logic signed [15:0]   up_reg [3];

    // scratch
    efcu_pkg::efcu_in_t  in_reg;
    efcu_pkg::efcu_out_t out_reg;
    logic [31:0]         vel_reg;
    logic [24:0]         wrap_reg;
    logic signed [33:0]  cx_reg, cy_reg;
    logic signed [25:0]  cz_reg;
    logic                flip_reg;
    logic signed [33:0]  cos_yaw_reg, sin_yaw_reg, cos_pitch_reg, sin_pitch_reg;
    logic signed [32:0]  raw_reg [3];
    logic [63:0]         sum_reg;
    logic [63:0]         root_reg;
    logic [31:0]         len_reg;
    logic [46:0]         rem_reg;
    logic [14:0]         quo_reg;
    logic signed [65:0]  prod_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= efcu_pkg::SPEED_RST;
            sens_reg  <= efcu_pkg::SENS_RST;
            wu_reg[0] <= 16'sd0;
            wu_reg[1] <= efcu_pkg::ONE_Q14;
            wu_reg[2] <= 16'sd0;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                efcu_pkg::REG_SPEED: speed_reg <= pwdata[15:0];
                efcu_pkg::REG_SENS:  sens_reg  <= pwdata[15:0];
                efcu_pkg::REG_WUP_X: wu_reg[0] <= pwdata[15:0];
                efcu_pkg::REG_WUP_Y: wu_reg[1] <= pwdata[15:0];
                efcu_pkg::REG_WUP_Z: wu_reg[2] <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            efcu_pkg::REG_SPEED: prdata = {16'd0, speed_reg};
            efcu_pkg::REG_SENS:  prdata = {16'd0, sens_reg};
            efcu_pkg::REG_WUP_X: prdata = {16'd0, wu_reg[0]};
            efcu_pkg::REG_WUP_Y: prdata = {16'd0, wu_reg[1]};
            efcu_pkg::REG_WUP_Z: prdata = {16'd0, wu_reg[2]};
            default:             prdata = 32'd0;
        endcase
    end

    // ---------------- datapath helpers ----------------
    logic [2:0]         dir;
    logic               mv_en, mv_neg;
    logic signed [15:0] mv_comp;
    logic [1:0]         jdx, kdx;

    assign dir    = in_reg.move_direction;
    assign mv_en  = (dir >= efcu_pkg::DIR_FORWARD) && (dir <= efcu_pkg::DIR_DOWN);
    assign mv_neg = (dir == efcu_pkg::DIR_BACKWARD) || (dir == efcu_pkg::DIR_LEFT) ||
                    (dir == efcu_pkg::DIR_DOWN);
    assign jdx    = (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
    assign kdx    = (idx_reg == 2'd0) ? 2'd2 : idx_reg - 2'd1;

    always_comb begin
        case (dir)
            efcu_pkg::DIR_FORWARD, efcu_pkg::DIR_BACKWARD: mv_comp = front_reg[idx_reg];
            efcu_pkg::DIR_LEFT, efcu_pkg::DIR_RIGHT:       mv_comp = right_reg[idx_reg];
            default:                                       mv_comp = wu_reg[idx_reg];
        endcase
    end

    // cross product operands: front x world_up, then right x front
    logic signed [15:0] ca [3];
    logic signed [15:0] cb [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (vsel_reg == efcu_pkg::VSEL_RIGHT) begin
                ca[i] = front_reg[i];
                cb[i] = wu_reg[i];
            end else begin
                ca[i] = right_reg[i];
                cb[i] = front_reg[i];
            end
        end
    end

    // shared multiplier operands
    logic signed [32:0] mul_a, mul_b;

    always_comb begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
        case (state_reg)
            efcu_pkg::ST_VEL: begin
                mul_a = $signed({17'd0, speed_reg});
                mul_b = $signed({17'd0, in_reg.delta_time});
            end
            efcu_pkg::ST_MOVE: begin
                mul_a = 33'(mv_comp);
                mul_b = $signed({1'b0, vel_reg});
            end
            efcu_pkg::ST_YAW_MUL: begin
                mul_a = 33'(in_reg.mouse_dx);
                mul_b = $signed({17'd0, sens_reg});
            end
            efcu_pkg::ST_PITCH_MUL: begin
                mul_a = 33'(in_reg.mouse_dy);
                mul_b = $signed({17'd0, sens_reg});
            end
            efcu_pkg::ST_FRONT: begin
                mul_a = (idx_reg == 2'd0) ? 33'(cos_yaw_reg) : 33'(sin_yaw_reg);
                mul_b = 33'(cos_pitch_reg);
            end
            efcu_pkg::ST_SQ: begin
                mul_a = raw_reg[idx_reg];
                mul_b = raw_reg[idx_reg];
            end
            efcu_pkg::ST_CROSS: begin
                mul_a = cnt_reg[0] ? 33'(ca[kdx]) : 33'(ca[jdx]);
                mul_b = cnt_reg[0] ? 33'(cb[jdx]) : 33'(cb[kdx]);
            end
            default: ;
        endcase
    end

    // position step with saturation
    logic signed [65:0]   step_rnd;
    logic signed [SW-1:0] step_d, pos_ext, pos_sum, pos_sat;

    always_comb begin
        step_rnd = prod_reg + 66'sd2097152;
        step_d   = SW'(step_rnd >>> 22);
        pos_ext  = SW'(pos_reg[idx_reg]);
        pos_sum  = mv_neg ? pos_ext - step_d : pos_ext + step_d;
        if (pos_sum > POS_MAX) begin
            pos_sat = POS_MAX;
        end else if (pos_sum < POS_MIN) begin
            pos_sat = POS_MIN;
        end else begin
            pos_sat = pos_sum;
        end
    end

    // angle update, clamp and wrap preparation
    logic signed [26:0] ang_off, ang_base, ang_sum, ang_clamp, ang_t;
    logic [24:0]        wrap_load;

    always_comb begin
        ang_off  = 27'((prod_reg + 66'sd256) >>> 9);
        ang_base = (state_reg == efcu_pkg::ST_PITCH_MUL) ? 27'(pitch_reg) : 27'(yaw_reg);
        ang_sum  = ang_base + ang_off;
        ang_clamp = ang_sum;
        if (state_reg == efcu_pkg::ST_PITCH_MUL && in_reg.constrain_pitch) begin
            if (ang_sum > 27'(efcu_pkg::PITCH_LIM)) begin
                ang_clamp = 27'(efcu_pkg::PITCH_LIM);
            end else if (ang_sum < -27'(efcu_pkg::PITCH_LIM)) begin
                ang_clamp = -27'(efcu_pkg::PITCH_LIM);
            end
        end
        ang_t = ang_clamp + 27'(efcu_pkg::DEG180);
        // shift negatives up by 128 turns, then reduce by shifted subtraction
        if (ang_t < 27'sd0) begin
            ang_t = ang_t + 27'(efcu_pkg::DEG360 * 128);
        end
        wrap_load = 25'(ang_t);
    end

    logic [24:0]        wrap_cmp, wrap_step;
    logic signed [15:0] wrap_angle;

    always_comb begin
        wrap_cmp   = 25'(efcu_pkg::DEG360) << cnt_reg[2:0];
        wrap_step  = (wrap_reg >= wrap_cmp) ? wrap_reg - wrap_cmp : wrap_reg;
        wrap_angle = 16'(wrap_step - 25'(efcu_pkg::DEG180));
    end

    // CORDIC start and rotation step
    logic signed [15:0] ci_ang;
    logic signed [16:0] ci_red;
    logic               ci_flip;
    logic signed [33:0] cr_dx, cr_dy, cx_nx, cy_nx;
    logic signed [25:0] cr_at, cz_nx;

    always_comb begin
        ci_ang  = asel_reg ? pitch_reg : yaw_reg;
        ci_red  = 17'(ci_ang);
        ci_flip = 1'b0;
        if (ci_ang > 16'(efcu_pkg::DEG90)) begin
            ci_red  = 17'(ci_ang) - 17'(efcu_pkg::DEG180);
            ci_flip = 1'b1;
        end else if (ci_ang < -16'(efcu_pkg::DEG90)) begin
            ci_red  = 17'(ci_ang) + 17'(efcu_pkg::DEG180);
            ci_flip = 1'b1;
        end
        cr_dx = cy_reg >>> cnt_reg;
        cr_dy = cx_reg >>> cnt_reg;
        cr_at = efcu_pkg::atan_entry(cnt_reg);
        if (!cz_reg[25]) begin
            cx_nx = cx_reg - cr_dx;
            cy_nx = cy_reg + cr_dy;
            cz_nx = cz_reg - cr_at;
        end else begin
            cx_nx = cx_reg + cr_dx;
            cy_nx = cy_reg - cr_dy;
            cz_nx = cz_reg + cr_at;
        end
    end

    // square root step
    logic [63:0] sq_bit, sq_trial, sum_nx, root_nx;

    always_comb begin
        sq_bit   = 64'd1 << {cnt_reg, 1'b0};
        sq_trial = root_reg + sq_bit;
        if (sum_reg >= sq_trial) begin
            sum_nx  = sum_reg - sq_trial;
            root_nx = (root_reg >> 1) + sq_bit;
        end else begin
            sum_nx  = sum_reg;
            root_nx = root_reg >> 1;
        end
    end

    // rounded quotient |c| * 16384 / len, one bit a cycle
    logic signed [32:0] raw_sel;
    logic [32:0]        raw_mag;
    logic [46:0]        rem_init, div_cmp, rem_nx;
    logic [14:0]        quo_nx;
    logic signed [15:0] norm_q;

    always_comb begin
        raw_sel  = raw_reg[idx_reg];
        raw_mag  = raw_sel[32] ? 33'(-raw_sel) : 33'(raw_sel);
        rem_init = (47'(raw_mag) << 14) + 47'(len_reg >> 1);
        div_cmp  = 47'(len_reg) << cnt_reg[3:0];
        if (rem_reg >= div_cmp) begin
            rem_nx = rem_reg - div_cmp;
            quo_nx = quo_reg | (15'd1 << cnt_reg[3:0]);
        end else begin
            rem_nx = rem_reg;
            quo_nx = quo_reg;
        end
        norm_q = raw_sel[32] ? -$signed(16'(quo_nx)) : $signed(16'(quo_nx));
    end

    // ---------------- sequencer ----------------
    efcu_pkg::state_t an_state;
    efcu_pkg::vsel_t  an_vsel;

    // where to go once a vector is normalized (or left as it was)
    always_comb begin
        case (vsel_reg)
            efcu_pkg::VSEL_FRONT: begin
                an_state = efcu_pkg::ST_CROSS;
                an_vsel  = efcu_pkg::VSEL_RIGHT;
            end
            efcu_pkg::VSEL_RIGHT: begin
                an_state = efcu_pkg::ST_CROSS;
                an_vsel  = efcu_pkg::VSEL_UP;
            end
            default: begin
                an_state = efcu_pkg::ST_DONE;
                an_vsel  = vsel_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= efcu_pkg::ST_IDLE;
            vsel_reg  <= efcu_pkg::VSEL_FRONT;
            ph_reg    <= 1'b0;
            idx_reg   <= 2'd0;
            cnt_reg   <= 5'd0;
            asel_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            vsel_reg  <= vsel_next;
            ph_reg    <= ph_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            asel_reg  <= asel_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        vsel_next  = vsel_reg;
        ph_next    = ph_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        asel_next  = asel_reg;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            efcu_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = efcu_pkg::ST_VEL;
                    ph_next    = 1'b0;
                end
            end
            efcu_pkg::ST_VEL: begin
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    idx_next   = 2'd0;
                    state_next = mv_en ? efcu_pkg::ST_MOVE : efcu_pkg::ST_YAW_MUL;
                end
            end
            efcu_pkg::ST_MOVE: begin
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    if (idx_reg == 2'd2) begin
                        idx_next   = 2'd0;
                        state_next = efcu_pkg::ST_YAW_MUL;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            efcu_pkg::ST_YAW_MUL: begin
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    asel_next  = 1'b0;
                    cnt_next   = 5'd7;
                    state_next = efcu_pkg::ST_WRAP;
                end
            end
            efcu_pkg::ST_PITCH_MUL: begin
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    asel_next  = 1'b1;
                    cnt_next   = 5'd7;
                    state_next = efcu_pkg::ST_WRAP;
                end
            end
            efcu_pkg::ST_WRAP: begin
                if (cnt_reg == 5'd0) begin
                    if (!asel_reg) begin
                        state_next = efcu_pkg::ST_PITCH_MUL;
                    end else begin
                        asel_next  = 1'b0;
                        state_next = efcu_pkg::ST_CINIT;
                    end
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            efcu_pkg::ST_CINIT: begin
                cnt_next   = 5'd0;
                state_next = efcu_pkg::ST_CORDIC;
            end
            efcu_pkg::ST_CORDIC: begin
                if (cnt_reg == CS_LAST) begin
                    if (!asel_reg) begin
                        asel_next  = 1'b1;
                        state_next = efcu_pkg::ST_CINIT;
                    end else begin
                        idx_next   = 2'd0;
                        ph_next    = 1'b0;
                        state_next = efcu_pkg::ST_FRONT;
                    end
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            efcu_pkg::ST_FRONT: begin
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    if (idx_reg == 2'd1) begin
                        idx_next   = 2'd0;
                        vsel_next  = efcu_pkg::VSEL_FRONT;
                        state_next = efcu_pkg::ST_SQ;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            efcu_pkg::ST_SQ: begin
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    if (idx_reg == 2'd2) begin
                        idx_next   = 2'd0;
                        cnt_next   = 5'd31;
                        state_next = efcu_pkg::ST_SQRT;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            efcu_pkg::ST_SQRT: begin
                if (cnt_reg == 5'd0) begin
                    ph_next  = 1'b0;
                    idx_next = 2'd0;
                    if (root_nx == 64'd0) begin
                        // zero length: vector keeps its previous value
                        cnt_next   = 5'd0;
                        vsel_next  = an_vsel;
                        state_next = an_state;
                    end else begin
                        state_next = efcu_pkg::ST_DIV;
                    end
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            efcu_pkg::ST_DIV: begin
                if (!ph_reg) begin
                    ph_next  = 1'b1;
                    cnt_next = 5'd14;
                end else if (cnt_reg == 5'd0) begin
                    ph_next = 1'b0;
                    if (idx_reg == 2'd2) begin
                        idx_next   = 2'd0;
                        vsel_next  = an_vsel;
                        state_next = an_state;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            efcu_pkg::ST_CROSS: begin
                ph_next = ~ph_reg;
                if (ph_reg) begin
                    if (!cnt_reg[0]) begin
                        cnt_next = 5'd1;
                    end else begin
                        cnt_next = 5'd0;
                        if (idx_reg == 2'd2) begin
                            idx_next   = 2'd0;
                            state_next = efcu_pkg::ST_SQ;
                        end else begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                end
            end
            efcu_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = efcu_pkg::ST_IDLE;
                end
            end
            default: state_next = efcu_pkg::ST_IDLE;
        endcase
    end

    // ---------------- camera state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= '0;
            end
            yaw_reg      <= efcu_pkg::YAW_RST;
            pitch_reg    <= 16'sd0;
            zoom_reg     <= efcu_pkg::ZOOM_MAX;
            front_reg[0] <= 16'sd0;
            front_reg[1] <= 16'sd0;
            front_reg[2] <= -efcu_pkg::ONE_Q14;
            right_reg[0] <= efcu_pkg::ONE_Q14;
            right_reg[1] <= 16'sd0;
            right_reg[2] <= 16'sd0;
            up_reg[0]    <= 16'sd0;
            up_reg[1]    <= efcu_pkg::ONE_Q14;
            up_reg[2]    <= 16'sd0;
        end else begin
            if (state_reg == efcu_pkg::ST_VEL && ph_reg) begin
                logic signed [17:0] zt;
                zt = 18'($signed({1'b0, zoom_reg})) - 18'(in_reg.scroll_offset);
                if (zt < 18'($signed({1'b0, efcu_pkg::ZOOM_MIN}))) begin
                    zoom_reg <= efcu_pkg::ZOOM_MIN;
                end else if (zt > 18'($signed({1'b0, efcu_pkg::ZOOM_MAX}))) begin
                    zoom_reg <= efcu_pkg::ZOOM_MAX;
                end else begin
                    zoom_reg <= 14'(zt);
                end
            end
            if (state_reg == efcu_pkg::ST_MOVE && ph_reg) begin
                pos_reg[idx_reg] <= PW'(pos_sat);
            end
            if (state_reg == efcu_pkg::ST_WRAP && cnt_reg == 5'd0) begin
                if (!asel_reg) begin
                    yaw_reg <= wrap_angle;
                end else begin
                    pitch_reg <= wrap_angle;
                end
            end
            if (state_reg == efcu_pkg::ST_DIV && ph_reg && cnt_reg == 5'd0) begin
                case (vsel_reg)
                    efcu_pkg::VSEL_FRONT: front_reg[idx_reg] <= norm_q;
                    efcu_pkg::VSEL_RIGHT: right_reg[idx_reg] <= norm_q;
                    default:              up_reg[idx_reg]    <= norm_q;
                endcase
            end
        end
    end

    // ---------------- scratch datapath ----------------
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (state_reg == efcu_pkg::ST_IDLE && s_valid) begin
            in_reg <= s_data;
        end
        case (state_reg)
            efcu_pkg::ST_VEL: begin
                if (ph_reg) begin
                    vel_reg <= prod_reg[31:0];
                end
            end
            efcu_pkg::ST_YAW_MUL, efcu_pkg::ST_PITCH_MUL: begin
                if (ph_reg) begin
                    wrap_reg <= wrap_load;
                end
            end
            efcu_pkg::ST_WRAP: begin
                wrap_reg <= wrap_step;
            end
            efcu_pkg::ST_CINIT: begin
                cx_reg   <= 34'(efcu_pkg::CORDIC_GAIN);
                cy_reg   <= 34'sd0;
                cz_reg   <= 26'(ci_red) <<< 9;
                flip_reg <= ci_flip;
            end
            efcu_pkg::ST_CORDIC: begin
                cx_reg <= cx_nx;
                cy_reg <= cy_nx;
                cz_reg <= cz_nx;
                if (cnt_reg == CS_LAST) begin
                    if (!asel_reg) begin
                        cos_yaw_reg <= flip_reg ? -cx_nx : cx_nx;
                        sin_yaw_reg <= flip_reg ? -cy_nx : cy_nx;
                    end else begin
                        cos_pitch_reg <= flip_reg ? -cx_nx : cx_nx;
                        sin_pitch_reg <= flip_reg ? -cy_nx : cy_nx;
                    end
                end
            end
            efcu_pkg::ST_FRONT: begin
                if (ph_reg) begin
                    raw_reg[1] <= 33'(sin_pitch_reg);
                    if (idx_reg == 2'd0) begin
                        raw_reg[0] <= 33'(prod_reg >>> 30);
                    end else begin
                        raw_reg[2] <= 33'(prod_reg >>> 30);
                    end
                end
            end
            efcu_pkg::ST_SQ: begin
                if (ph_reg) begin
                    sum_reg  <= ((idx_reg == 2'd0) ? 64'd0 : sum_reg) + prod_reg[63:0];
                    root_reg <= 64'd0;
                end
            end
            efcu_pkg::ST_SQRT: begin
                sum_reg  <= sum_nx;
                root_reg <= root_nx;
                if (cnt_reg == 5'd0) begin
                    len_reg <= root_nx[31:0];
                end
            end
            efcu_pkg::ST_DIV: begin
                if (!ph_reg) begin
                    rem_reg <= rem_init;
                    quo_reg <= 15'd0;
                end else begin
                    rem_reg <= rem_nx;
                    quo_reg <= quo_nx;
                end
            end
            efcu_pkg::ST_CROSS: begin
                if (ph_reg) begin
                    if (!cnt_reg[0]) begin
                        raw_reg[idx_reg] <= 33'(prod_reg);
                    end else begin
                        raw_reg[idx_reg] <= raw_reg[idx_reg] - 33'(prod_reg);
                    end
                end
            end
            default: ;
        endcase
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg.pos_x       <= 32'(64'(pos_reg[0]));
            out_reg.pos_y       <= 32'(64'(pos_reg[1]));
            out_reg.pos_z       <= 32'(64'(pos_reg[2]));
            out_reg.front_x     <= front_reg[0];
            out_reg.front_y     <= front_reg[1];
            out_reg.front_z     <= front_reg[2];
            out_reg.up_x        <= up_reg[0];
            out_reg.up_y        <= up_reg[1];
            out_reg.up_z        <= up_reg[2];
            out_reg.yaw_angle   <= yaw_reg;
            out_reg.pitch_angle <= pitch_reg;
            out_reg.zoom_level  <= zoom_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
